[hw/rtl/tmh_pkg.sv]
// Shared types and constants for the ternary max-heap insert block.
// Holds default sizes, field widths and command/status codes.
// No dependencies.
package tmh_pkg;

  // Default heap geometry
  localparam int CAPACITY_DEF = 1024;
  localparam int ARITY_DEF    = 3;

  // Fixed field widths of the item ports
  localparam int KEY_W   = 32;
  localparam int INDEX_W = 10;
  localparam int POS_W   = 10;
  localparam int TOTAL_W = 11;
  localparam int STAT_W  = 2;

  // Command codes
  typedef enum logic {
    CMD_INSERT   = 1'b0,
    CMD_INCREASE = 1'b1
  } cmd_t;

  // Status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_SMALLER = 2'd3
  } status_t;

endpackage

[hw/rtl/ternary_max_heap_insert.sv]
// Array-held d-ary max-heap with insert and increase-key commands.
// Keys live in one synchronous RAM; sift-up moves a hole toward the root.
// Depends on tmh_pkg.
//
//  channel | direction | fields                                          | handshake
//  in_     | input     | command, key, index                             | in_valid/in_ready
//  out_    | output    | status, final_position, entry_total, top_key    | out_valid/out_ready
//
// A full store or an index past the count goes straight to the result; a refused smaller
// key costs one RAM read first. Otherwise the key climbs L levels (up to 6 for 1024
// entries at arity 3). Each level costs one cycle: the RAM read of the parent overlaps
// the write of the hole below it.
// Reset empties the heap (count to zero); RAM contents need no clearing.
// in_ready is high only while no item is in progress; a finished result waits in the
// output register until taken, and the sequencer holds in its last state meanwhile.
module ternary_max_heap_insert #(
  parameter int CAPACITY = tmh_pkg::CAPACITY_DEF,
  parameter int ARITY    = tmh_pkg::ARITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_command,
  input  logic signed [tmh_pkg::KEY_W-1:0]  in_key,
  input  logic [tmh_pkg::INDEX_W-1:0]       in_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tmh_pkg::STAT_W-1:0]        out_status,
  output logic [tmh_pkg::POS_W-1:0]         out_final_position,
  output logic [tmh_pkg::TOTAL_W-1:0]       out_entry_total,
  output logic signed [tmh_pkg::KEY_W-1:0]  out_top_key
);

  localparam int KW   = tmh_pkg::KEY_W;
  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > tmh_pkg::INDEX_W) ? CW : tmh_pkg::INDEX_W;
  // Reciprocal for the parent rule (p-1)/ARITY, exact for p below 2**AW
  localparam int SH   = AW + $clog2(ARITY);
  localparam int RW   = SH + 1;
  localparam longint unsigned RECIP = ((64'd1 << SH) + ARITY - 1) / ARITY;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_CUR,
    S_CMP,
    S_PLACE,
    S_FINISH
  } state_t;

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
    logic [AW+RW-1:0] prod;
    prod = (AW + RW)'(p - 1'b1) * (AW + RW)'(RECIP);
    return AW'(prod >> SH);
  endfunction

  // Registers
  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic signed [KW-1:0]    mkey_r, mkey_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;
  logic [AW-1:0]           par_r, par_nxt;
  tmh_pkg::status_t        stat_r, stat_nxt;
  logic signed [KW-1:0]    top_r, top_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [tmh_pkg::STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [tmh_pkg::POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic [tmh_pkg::TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic signed [KW-1:0]    out_top_r, out_top_nxt;

  // RAM and its ports
  logic signed [KW-1:0]    heap_mem [CAPACITY];
  logic signed [KW-1:0]    rdata_r;
  logic                    rd_en, wr_en;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic signed [KW-1:0]    wr_data;

  logic                    in_acc;
  logic [AW-1:0]           div_in;
  logic [AW-1:0]           div_out;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign div_out  = parent_of(div_in);

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_final_position = out_pos_r;
  assign out_entry_total    = out_total_r;
  assign out_top_key        = out_top_r;

  // Sequencer next state and RAM control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    mkey_nxt      = mkey_r;
    pos_nxt       = pos_r;
    par_nxt       = par_r;
    stat_nxt      = stat_r;
    top_nxt       = top_r;
    out_valid_nxt = out_valid_r;
    out_status_nxt = out_status_r;
    out_pos_nxt   = out_pos_r;
    out_total_nxt = out_total_r;
    out_top_nxt   = out_top_r;
    rd_en         = 1'b0;
    rd_addr       = pos_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = mkey_r;
    div_in        = par_r;

    // Result leaves when taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        div_in = AW'(count_r);
        if (in_acc) begin
          mkey_nxt = in_key;
          stat_nxt = tmh_pkg::ST_DONE;
          pos_nxt  = '0;
          if (in_command == tmh_pkg::CMD_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              stat_nxt  = tmh_pkg::ST_FULL;
              state_nxt = S_FINISH;
            end else begin
              // Hole opens at the end of the heap
              count_nxt = count_r + 1'b1;
              pos_nxt   = AW'(count_r);
              if (count_r == '0) begin
                state_nxt = S_PLACE;
              end else begin
                par_nxt   = div_out;
                rd_en     = 1'b1;
                rd_addr   = div_out;
                state_nxt = S_CMP;
              end
            end
          end else begin
            if (CMPW'(in_index) >= CMPW'(count_r)) begin
              stat_nxt  = tmh_pkg::ST_RANGE;
              state_nxt = S_FINISH;
            end else begin
              pos_nxt   = AW'(in_index);
              rd_en     = 1'b1;
              rd_addr   = AW'(in_index);
              state_nxt = S_RD_CUR;
            end
          end
        end
      end

      // Check the new key against the one held at index
      S_RD_CUR: begin
        div_in = pos_r;
        if (mkey_r < rdata_r) begin
          stat_nxt  = tmh_pkg::ST_SMALLER;
          state_nxt = S_FINISH;
        end else if (pos_r == '0) begin
          state_nxt = S_PLACE;
        end else begin
          par_nxt   = div_out;
          rd_en     = 1'b1;
          rd_addr   = div_out;
          state_nxt = S_CMP;
        end
      end

      // One level per cycle: move the parent down or drop the key in place
      S_CMP: begin
        div_in = par_r;
        if (rdata_r < mkey_r) begin
          wr_en   = 1'b1;
          wr_addr = pos_r;
          wr_data = rdata_r;
          pos_nxt = par_r;
          if (par_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            par_nxt = div_out;
            rd_en   = 1'b1;
            rd_addr = div_out;
          end
        end else begin
          wr_en     = 1'b1;
          wr_addr   = pos_r;
          wr_data   = mkey_r;
          state_nxt = S_FINISH;
        end
      end

      S_PLACE: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = mkey_r;
        if (pos_r == '0) begin
          top_nxt = mkey_r;
        end
        state_nxt = S_FINISH;
      end

      // Load the output register once it is free
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_pos_nxt    = tmh_pkg::POS_W'(pos_r);
          out_total_nxt  = tmh_pkg::TOTAL_W'(count_r);
          out_top_nxt    = (count_r == '0) ? '0 : top_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mkey_r       <= mkey_nxt;
    pos_r        <= pos_nxt;
    par_r        <= par_nxt;
    stat_r       <= stat_nxt;
    top_r        <= top_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_total_r  <= out_total_nxt;
    out_top_r    <= out_top_nxt;
  end

  // Key RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= heap_mem[rd_addr];
    end
  end

endmodule
